[rtl/core/ffr_pkg.sv]
// Shared types and constants for the first-fit free run finder core.
// No dependencies; used by first_fit_free_run_finder_core.
`timescale 1ns / 1ps
`default_nettype none

package ffr_pkg;

  // Occupancy map geometry
  localparam int unsigned UNIVERSE  = 4096;
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned HALF_W    = WORD_W / 2;
  localparam int unsigned NUM_WORDS = UNIVERSE / WORD_W;
  localparam int unsigned ADDR_W    = $clog2(NUM_WORDS);
  localparam int unsigned BIT_W     = $clog2(WORD_W);
  localparam int unsigned LANE_W    = $clog2(HALF_W);
  localparam int unsigned POS_W     = 13;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned STATUS_W  = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP_INS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABS_REM = 2'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] run_length;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0]    run_start;
    logic [STATUS_W-1:0] status;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_SCAN_LO,
    S_SCAN_HI,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

[rtl/core/first_fit_free_run_finder_core.sv]
// First-fit free run finder: occupancy bitmap in a 64 x 64-bit synchronous RAM.
// Depends on ffr_pkg (types, op/status codes, map geometry).
`timescale 1ns / 1ps
`default_nettype none

// Keeps the set of occupied positions 1..4096 as a bitmap held in a 64-word by
// 64-bit RAM with a registered read. Insert and remove do one read, one bit
// test and one write back before the result is loaded. A query walks the map
// from word 0, one 32-bit half-word per cycle, carrying the start of the
// current free run; it stops at the first run of at least run_length free
// positions, or after the last word reports the run after the last member.
// Invalid ops, out-of-range positions and zero-length queries finish without
// touching the RAM. One transaction is in flight at a time; the output
// register lets a new transaction be accepted while the previous result
// still waits. No clearing pass is needed after reset: each RAM word has a
// valid flop cleared by reset, and a word never written reads as all free.

module first_fit_free_run_finder_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire ffr_pkg::in_t in_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output ffr_pkg::out_t     out_o
);

  localparam int unsigned LVLS = ffr_pkg::LANE_W;

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  ffr_pkg::state_e state_q, state_d;

  ffr_pkg::in_t                      req_q, req_d;
  logic [ffr_pkg::ADDR_W-1:0]        word_q, word_d;       // word being scanned
  logic [ffr_pkg::POS_W-1:0]         start_q, start_d;     // start of open free run
  logic [ffr_pkg::POS_W-1:0]         res_start_q, res_start_d;
  logic [ffr_pkg::STATUS_W-1:0]      res_status_q, res_status_d;

  ffr_pkg::out_t                     out_q;
  logic                              out_valid_q;
  logic                              out_load;

  // ---------------------------------------------------------------------------
  // Occupancy RAM with per-word valid flops (reset clears them all at once)
  // ---------------------------------------------------------------------------
  logic [ffr_pkg::WORD_W-1:0]   mem [ffr_pkg::NUM_WORDS];
  logic [ffr_pkg::WORD_W-1:0]   rd_raw_q;
  logic                         rd_live_q;
  logic [ffr_pkg::NUM_WORDS-1:0] word_vld_q;

  logic                         rd_en;
  logic [ffr_pkg::ADDR_W-1:0]   rd_addr;
  logic                         wr_en;
  logic [ffr_pkg::ADDR_W-1:0]   wr_addr;
  logic [ffr_pkg::WORD_W-1:0]   wr_data;
  logic [ffr_pkg::WORD_W-1:0]   word_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_vld_q <= '0;
      rd_live_q  <= 1'b0;
    end else begin
      if (wr_en) begin
        word_vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_live_q <= word_vld_q[rd_addr];
      end
    end
  end

  // A word never written holds no members.
  assign word_data = rd_live_q ? rd_raw_q : '0;

  // ---------------------------------------------------------------------------
  // Position decode (bit index = position - 1)
  // ---------------------------------------------------------------------------
  logic [ffr_pkg::POS_W-1:0]  in_bidx, req_bidx;
  logic                       in_pos_ok;
  logic [ffr_pkg::BIT_W-1:0]  req_bit;
  logic                       req_cur;
  logic [ffr_pkg::WORD_W-1:0] req_mask;

  assign in_bidx   = in_i.position - ffr_pkg::POS_W'(1);
  assign in_pos_ok = (in_i.position != '0) &&
                     (in_i.position <= ffr_pkg::POS_W'(ffr_pkg::UNIVERSE));
  assign req_bidx  = req_q.position - ffr_pkg::POS_W'(1);
  assign req_bit   = req_bidx[ffr_pkg::BIT_W-1:0];
  assign req_cur   = word_data[req_bit];
  assign req_mask  = ffr_pkg::WORD_W'(1) << req_bit;

  // ---------------------------------------------------------------------------
  // Half-word scan lanes
  // For every lane, find the nearest occupied lane at or below it with a
  // log-step prefix; the free run ending at a lane then starts right after
  // that member, or at the carried start when the half has none below.
  // ---------------------------------------------------------------------------
  logic                        scan_half;
  logic [ffr_pkg::HALF_W-1:0]  half_bits;
  logic                        has_p [LVLS+1][ffr_pkg::HALF_W];
  logic [ffr_pkg::LANE_W-1:0]  idx_p [LVLS+1][ffr_pkg::HALF_W];
  logic [ffr_pkg::POS_W-1:0]   lane_start [ffr_pkg::HALF_W];
  logic [ffr_pkg::POS_W-1:0]   lane_pos;
  logic [ffr_pkg::POS_W-1:0]   lane_len;
  logic                        scan_hit;
  logic [ffr_pkg::POS_W-1:0]   hit_start;
  logic [ffr_pkg::POS_W-1:0]   end_start;

  assign scan_half = (state_q == ffr_pkg::S_SCAN_HI);
  assign half_bits = scan_half ? word_data[ffr_pkg::WORD_W-1:ffr_pkg::HALF_W]
                               : word_data[ffr_pkg::HALF_W-1:0];

  always_comb begin
    for (int i = 0; i < ffr_pkg::HALF_W; i++) begin
      has_p[0][i] = half_bits[i];
      idx_p[0][i] = ffr_pkg::LANE_W'(i);
    end
    for (int l = 0; l < LVLS; l++) begin
      for (int i = 0; i < ffr_pkg::HALF_W; i++) begin
        if (i >= (1 << l) && !has_p[l][i]) begin
          has_p[l+1][i] = has_p[l][i - (1 << l)];
          idx_p[l+1][i] = idx_p[l][i - (1 << l)];
        end else begin
          has_p[l+1][i] = has_p[l][i];
          idx_p[l+1][i] = idx_p[l][i];
        end
      end
    end
  end

  always_comb begin
    scan_hit  = 1'b0;
    hit_start = start_q;
    lane_pos  = '0;
    lane_len  = '0;
    for (int i = ffr_pkg::HALF_W - 1; i >= 0; i--) begin
      // lane_pos is the 0-based map index of this lane
      lane_pos = {1'b0, word_q, scan_half, ffr_pkg::LANE_W'(i)};
      if (has_p[LVLS][i]) begin
        lane_start[i] = {1'b0, word_q, scan_half, idx_p[LVLS][i]} + ffr_pkg::POS_W'(2);
      end else begin
        lane_start[i] = start_q;
      end
      lane_len = lane_pos + ffr_pkg::POS_W'(2) - lane_start[i];
      // lowest qualifying lane wins (iterated last)
      if (!half_bits[i] && (lane_len >= req_q.run_length)) begin
        scan_hit  = 1'b1;
        hit_start = lane_start[i];
      end
    end
    end_start = lane_start[ffr_pkg::HALF_W-1];
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffr_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    word_q       <= word_d;
    start_q      <= start_d;
    res_start_q  <= res_start_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_q.run_start <= res_start_q;
      out_q.status    <= res_status_q;
    end
  end

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    word_d       = word_q;
    start_d      = start_q;
    res_start_d  = res_start_q;
    res_status_d = res_status_q;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = req_bidx[ffr_pkg::BIT_W +: ffr_pkg::ADDR_W];
    wr_data      = word_data;
    out_load     = 1'b0;
    in_ready_o   = 1'b0;

    unique case (state_q)
      ffr_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d        = in_i;
          res_start_d  = '0;
          res_status_d = ffr_pkg::ST_OK;
          case (in_i.op) inside
            ffr_pkg::OP_INSERT, ffr_pkg::OP_REMOVE: begin
              if (in_pos_ok) begin
                rd_en   = 1'b1;
                rd_addr = in_bidx[ffr_pkg::BIT_W +: ffr_pkg::ADDR_W];
                state_d = ffr_pkg::S_UPD;
              end else begin
                res_status_d = ffr_pkg::ST_INVALID;
                state_d      = ffr_pkg::S_DONE;
              end
            end
            ffr_pkg::OP_QUERY: begin
              if (in_i.run_length == '0) begin
                res_start_d = ffr_pkg::POS_W'(1);
                state_d     = ffr_pkg::S_DONE;
              end else begin
                rd_en   = 1'b1;
                rd_addr = '0;
                word_d  = '0;
                start_d = ffr_pkg::POS_W'(1);
                state_d = ffr_pkg::S_SCAN_LO;
              end
            end
            default: begin
              res_status_d = ffr_pkg::ST_INVALID;
              state_d      = ffr_pkg::S_DONE;
            end
          endcase
        end
      end

      ffr_pkg::S_UPD: begin
        // read-modify-write of one word; the next read comes only after S_DONE
        if (req_q.op == ffr_pkg::OP_INSERT) begin
          if (req_cur) begin
            res_status_d = ffr_pkg::ST_DUP_INS;
          end else begin
            wr_en   = 1'b1;
            wr_data = word_data | req_mask;
          end
        end else begin
          if (!req_cur) begin
            res_status_d = ffr_pkg::ST_ABS_REM;
          end else begin
            wr_en   = 1'b1;
            wr_data = word_data & ~req_mask;
          end
        end
        state_d = ffr_pkg::S_DONE;
      end

      ffr_pkg::S_SCAN_LO: begin
        if (scan_hit) begin
          res_start_d = hit_start;
          state_d     = ffr_pkg::S_DONE;
        end else begin
          start_d = end_start;
          state_d = ffr_pkg::S_SCAN_HI;
        end
      end

      ffr_pkg::S_SCAN_HI: begin
        if (scan_hit) begin
          res_start_d = hit_start;
          state_d     = ffr_pkg::S_DONE;
        end else if (word_q == ffr_pkg::ADDR_W'(ffr_pkg::NUM_WORDS - 1)) begin
          // run after the last member is unbounded
          res_start_d = end_start;
          state_d     = ffr_pkg::S_DONE;
        end else begin
          start_d = end_start;
          rd_en   = 1'b1;
          rd_addr = word_q + ffr_pkg::ADDR_W'(1);
          word_d  = word_q + ffr_pkg::ADDR_W'(1);
          state_d = ffr_pkg::S_SCAN_LO;
        end
      end

      ffr_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ffr_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = ffr_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A finished query always reports a real position.
  a_query_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ffr_pkg::S_DONE && req_q.op == ffr_pkg::OP_QUERY) |->
      (res_start_q != '0))
    else $error("query finished with run_start zero");

  // Map updates report no run start.
  a_update_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ffr_pkg::S_DONE && req_q.op != ffr_pkg::OP_QUERY) |->
      (res_start_q == '0))
    else $error("non-query finished with nonzero run_start");

  // Without a hit, the scan advances to the next word.
  a_scan_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ffr_pkg::S_SCAN_HI && !scan_hit &&
     word_q != ffr_pkg::ADDR_W'(ffr_pkg::NUM_WORDS - 1)) |=>
      (state_q == ffr_pkg::S_SCAN_LO && word_q == $past(word_q) + ffr_pkg::ADDR_W'(1)))
    else $error("scan did not advance to the next word");

  // The RAM is written only by the read-modify-write step.
  a_write_in_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == ffr_pkg::S_UPD && !rd_en))
    else $error("RAM write outside the update step");

endmodule

`default_nettype wire

[sim/ffr_run_monitor.sv]
// Transaction monitor and predictor for first_fit_free_run_finder_core.
// Depends on ffr_pkg (in_t, out_t, op/status codes, UNIVERSE).
`timescale 1ns / 1ps

module ffr_run_monitor
  import ffr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_i,
  output int   errors_o,
  output int   pending_o
);

  bit   occupied [1:UNIVERSE];
  out_t result_q [$];

  // lowest d with d..d+k-1 free; positions past the map are free
  function automatic logic [POS_W-1:0] first_free_run(input int unsigned k);
    int unsigned start;
    int unsigned len;
    start = 1;
    len   = 0;
    if (k == 0) return POS_W'(1);
    for (int unsigned p = 1; p <= UNIVERSE; p++) begin
      if (occupied[p]) begin
        start = p + 1;
        len   = 0;
      end else begin
        len++;
        if (len >= k) return POS_W'(start);
      end
    end
    return POS_W'(start);
  endfunction

  function automatic out_t apply_txn(input in_t t);
    out_t r;
    logic in_range;
    r        = '0;
    in_range = (t.position >= 1) && (t.position <= UNIVERSE);
    case (t.op)
      OP_INSERT: begin
        if (!in_range) r.status = ST_INVALID;
        else if (occupied[t.position]) r.status = ST_DUP_INS;
        else occupied[t.position] = 1'b1;
      end
      OP_REMOVE: begin
        if (!in_range) r.status = ST_INVALID;
        else if (!occupied[t.position]) r.status = ST_ABS_REM;
        else occupied[t.position] = 1'b0;
      end
      OP_QUERY: begin
        r.run_start = first_free_run(t.run_length);
      end
      default: begin
        r.status = ST_INVALID;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      for (int p = 1; p <= UNIVERSE; p++) occupied[p] = 1'b0;
      result_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      // result first: it always belongs to an earlier transaction
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result run_start %0d status %0d",
                   $time, out_i.run_start, out_i.status);
          errors_o++;
        end else begin
          want = result_q.pop_front();
          if (out_i.run_start !== want.run_start) begin
            $display("%0t: run_start mismatch, expected %0d, got %0d",
                     $time, want.run_start, out_i.run_start);
            errors_o++;
          end
          if (out_i.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, out_i.status);
            errors_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) result_q.push_back(apply_txn(in_i));
      pending_o = result_q.size();
    end
  end

endmodule

[sim/tb_first_fit_free_run_finder_core.sv]
// Top of the first_fit_free_run_finder_core testbench: clock, reset, stimulus, verdict.
// Depends on ffr_pkg, first_fit_free_run_finder_core and ffr_run_monitor.
`timescale 1ns / 1ps

module tb_first_fit_free_run_finder_core;
  import ffr_pkg::*;

  localparam int unsigned HALF_PERIOD  = 10;
  localparam int unsigned RESET_CYCLES = 8;
  localparam int unsigned RANDOM_TXNS  = 730;
  localparam int unsigned WINDOW_TXNS  = 120;
  // long receiver hold-off: fills the core and its output register
  localparam int unsigned HOLD_CYCLES  = 400;
  // long enough to cover a full query scan
  localparam int unsigned DRAIN_CYCLES = 300;
  // watchdog limit for a hung handshake
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned FIELD_MAX    = (1 << POS_W) - 1;
  // op code the core has no meaning for
  localparam logic [OP_W-1:0] OP_ILLEGAL = 2'd3;

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic in_ready;
  in_t  in_txn;
  logic out_valid;
  logic out_ready;
  out_t out_txn;

  int          mismatches;
  int          outstanding;
  int unsigned cycle_cnt;
  bit          hold_req;
  bit          hold_done;
  int          burst_left;

  // stimulus-side view of which positions are set, used only to steer
  // removes toward present positions
  bit          stim_held [1:UNIVERSE];
  int unsigned stim_held_q [$];

  first_fit_free_run_finder_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_txn),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_txn)
  );

  ffr_run_monitor u_monitor (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_i       (in_txn),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_i      (out_txn),
    .errors_o   (mismatches),
    .pending_o  (outstanding)
  );

  initial clk_i = 1'b0;
  always #HALF_PERIOD clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run here.
  initial cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_first_fit_free_run_finder_core: errors");
      $finish;
    end
  end

  // Offer one transaction and hold it until accepted. Inputs move only on
  // the falling edge; acceptance is judged from values seen at the rising
  // edge. Valid stays up between transactions of a burst, so it never gets
  // two assignments in one step.
  task automatic send_txn(input logic [OP_W-1:0] op, input int unsigned pos,
                          input int unsigned k);
    in_t         t;
    int          idx [$];
    int unsigned gap;
    t.op         = op;
    t.position   = pos[POS_W-1:0];
    t.run_length = k[POS_W-1:0];
    in_txn   <= t;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);

    if (pos >= 1 && pos <= UNIVERSE) begin
      if (op == OP_INSERT && !stim_held[pos]) begin
        stim_held[pos] = 1'b1;
        stim_held_q.push_back(pos);
      end else if (op == OP_REMOVE && stim_held[pos]) begin
        stim_held[pos] = 1'b0;
        idx = stim_held_q.find_first_index(x) with (x == pos);
        stim_held_q.delete(idx[0]);
      end
    end

    // end of burst: idle for a while, sometimes a long pause,
    // sometimes none at all
    burst_left--;
    if (burst_left <= 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        3:       gap = $urandom_range(20, 40);
        default: gap = $urandom_range(1, 6);
      endcase
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
  endtask

  // Run lengths: mostly short, some medium, a few that span most of the map,
  // and occasionally any 13-bit value (zero and past the map included).
  function automatic int unsigned pick_run_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 8);
    if (r < 85) return $urandom_range(9, 128);
    if (r < 95) return $urandom_range(129, UNIVERSE);
    return $urandom_range(0, FIELD_MAX);
  endfunction

  // Receiver: ready pattern changes mode every so often. Once, on request,
  // it holds off for HOLD_CYCLES while the sender keeps pushing.
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned tick;
    out_ready = 1'b0;
    tick      = 0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 200);
      repeat (span) begin
        @(negedge clk_i);
        tick++;
        if (hold_req && !hold_done) begin
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES - 1) @(negedge clk_i);
          hold_done = 1'b1;
        end else begin
          case (mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= $urandom_range(0, 1);
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (tick % 3 != 0);
          endcase
        end
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int unsigned base;
    int unsigned width;
    int unsigned r;
    int unsigned pos;
    in_valid   = 1'b0;
    in_txn     = '0;
    rst_ni     = 1'b0;
    hold_req   = 1'b0;
    burst_left = $urandom_range(1, 8);
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: empty map, zero and oversized run lengths, the end
    // positions, duplicate insert, absent remove, out-of-range positions,
    // the unused op, a run that ends past the map, and a 64-bit word edge.
    send_txn(OP_QUERY, 0, 1);
    send_txn(OP_QUERY, FIELD_MAX, 0);
    send_txn(OP_QUERY, 0, FIELD_MAX);
    send_txn(OP_INSERT, 1, FIELD_MAX);
    send_txn(OP_INSERT, 1, 0);
    send_txn(OP_INSERT, UNIVERSE, 0);
    send_txn(OP_QUERY, 0, 1);
    send_txn(OP_QUERY, 0, UNIVERSE - 1);      // no room inside: past the top
    send_txn(OP_QUERY, 0, UNIVERSE - 2);
    send_txn(OP_REMOVE, 7, 0);
    send_txn(OP_REMOVE, UNIVERSE, 0);
    send_txn(OP_INSERT, 0, 0);
    send_txn(OP_REMOVE, UNIVERSE + 1, 0);
    send_txn(OP_INSERT, FIELD_MAX, FIELD_MAX);
    send_txn(OP_ILLEGAL, 5, 5);
    send_txn(OP_ILLEGAL, FIELD_MAX, FIELD_MAX);
    send_txn(OP_QUERY, FIELD_MAX, 3);
    send_txn(OP_REMOVE, 1, 0);
    send_txn(OP_INSERT, 64, 0);
    send_txn(OP_INSERT, 65, 0);
    send_txn(OP_QUERY, 0, 63);
    send_txn(OP_QUERY, 0, 64);
    send_txn(OP_REMOVE, 64, FIELD_MAX);

    // Random part. Positions cluster in a window that moves every
    // WINDOW_TXNS transactions, so runs form, fill and break up; removes
    // mostly hit present positions. A small share is malformed.
    hold_req   = 1'b1;
    burst_left = 24;
    for (int unsigned n = 0; n < RANDOM_TXNS; n++) begin
      if (n % WINDOW_TXNS == 0) begin
        case ($urandom_range(0, 3))
          0:       width = 15;
          1:       width = 63;
          2:       width = 255;
          default: width = UNIVERSE - 1;
        endcase
        base = $urandom_range(1, UNIVERSE - width);
      end
      r = $urandom_range(0, 99);
      if (r < 40) begin
        send_txn(OP_INSERT, base + $urandom_range(0, width), $urandom_range(0, FIELD_MAX));
      end else if (r < 62) begin
        if (stim_held_q.size() > 0 && $urandom_range(0, 9) < 7)
          pos = stim_held_q[$urandom_range(0, stim_held_q.size() - 1)];
        else
          pos = base + $urandom_range(0, width);
        send_txn(OP_REMOVE, pos, $urandom_range(0, FIELD_MAX));
      end else if (r < 95) begin
        send_txn(OP_QUERY, $urandom_range(0, FIELD_MAX), pick_run_length());
      end else begin
        pos = $urandom_range(0, 1) ? 0 : $urandom_range(UNIVERSE + 1, FIELD_MAX);
        case ($urandom_range(0, 2))
          0:       send_txn(OP_INSERT, pos, $urandom_range(0, FIELD_MAX));
          1:       send_txn(OP_REMOVE, pos, $urandom_range(0, FIELD_MAX));
          default: send_txn(OP_ILLEGAL, $urandom_range(0, FIELD_MAX),
                            $urandom_range(0, FIELD_MAX));
        endcase
      end
    end
    in_valid <= 1'b0;

    // drain, then give the core time to show any stray result
    while (outstanding != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("tb_first_fit_free_run_finder_core: clean");
    end else begin
      $display("tb_first_fit_free_run_finder_core: errors");
    end
    $finish;
  end

endmodule
